@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the checker file erlf_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ERLF_ASSERT(LBL, CLK_SIG, RSTN_SIG, PROP) \
    LBL: assert property (@(posedge CLK_SIG) disable iff (!RSTN_SIG) PROP) \
        else $error("assertion failed");

// Property checked on every clock edge, reset included.
`define ERLF_ASSERT_ALWAYS(LBL, CLK_SIG, PROP) \
    LBL: assert property (@(posedge CLK_SIG) PROP) \
        else $error("assertion failed");

`endif

@@ rtl/erlf_pkg.sv @@
// ----------------------------------------------------------------------------
// erlf_pkg
// Types, constants and the exponential table for the root fraction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package erlf_pkg;

    localparam int EXP_BITS  = 33;   // exponent bits, Q13.20
    localparam int FRAC_BITS = 17;   // quotient bits, Q1.16
    localparam int REM_W     = 49;   // divider remainder width

    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [64:0] ROUND_Q32 = 65'h0_8000_0000;
    localparam logic [16:0] FRAC_ONE  = 17'h1_0000;

    typedef struct packed {
        logic        valid;
        logic        bare;
        logic [32:0] x_d;
        logic [32:0] x_1;
        logic [32:0] x_12;
        logic [32:0] e_d;
        logic [32:0] e_1;
        logic [32:0] e_12;
    } erlf_exp_t;

    typedef struct packed {
        logic             valid;
        logic             bare;
        logic             degen;
        logic             sat1;
        logic             sat2;
        logic [32:0]      den;
        logic [REM_W-1:0] rem1;
        logic [REM_W-1:0] rem2;
        logic [16:0]      q1;
        logic [16:0]      q2;
    } erlf_div_t;

    // truncating long division, used only while the table is built
    function automatic longint unsigned table_div(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-(2^(idx-20)) in Q0.32; evaluated at elaboration only.
    function automatic logic [31:0] exp_tab_entry(input int idx);
        longint unsigned term;
        longint unsigned sum;
        longint unsigned t;
        int              m;
        t = 64'd0;
        for (int i = 0; i <= idx; i++)
        begin
            if (i < 20)
            begin
                m    = 20 - i;
                term = 64'd1 << 60;
                sum  = 64'd1 << 60;
                for (longint unsigned n = 1; n <= 40; n++)
                begin
                    term = table_div(term >> m, n);
                    if (n[0])
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                t = (sum + (64'd1 << 27)) >> 28;
            end
            else
            begin
                t = (t * t + (64'd1 << 31)) >> 32;
            end
        end
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/erlf_exp_stage.sv @@
// ----------------------------------------------------------------------------
// erlf_exp_stage
// One bit of the e^-x product chain for all three exponents.
// ----------------------------------------------------------------------------
`default_nettype none

module erlf_exp_stage
    import erlf_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire erlf_exp_t stage_in,
    output erlf_exp_t      stage_out
);

    localparam logic [31:0] TAB_VAL = exp_tab_entry(BIT);

    erlf_exp_t   stage_reg;
    erlf_exp_t   stage_next;
    logic [64:0] prod_d;
    logic [64:0] prod_1;
    logic [64:0] prod_12;

    always_comb
    begin
        prod_d  = 65'(stage_in.e_d)  * 65'(TAB_VAL) + ROUND_Q32;
        prod_1  = 65'(stage_in.e_1)  * 65'(TAB_VAL) + ROUND_Q32;
        prod_12 = 65'(stage_in.e_12) * 65'(TAB_VAL) + ROUND_Q32;
        stage_next = stage_in;
        if (stage_in.x_d[BIT])
            stage_next.e_d = prod_d[64:32];
        if (stage_in.x_1[BIT])
            stage_next.e_1 = prod_1[64:32];
        if (stage_in.x_12[BIT])
            stage_next.e_12 = prod_12[64:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (advance)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

@@ rtl/erlf_ratio_prep.sv @@
// ----------------------------------------------------------------------------
// erlf_ratio_prep
// Forms denominator and numerators, then dividend and saturation flags.
// ----------------------------------------------------------------------------
`default_nettype none

module erlf_ratio_prep
    import erlf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire erlf_exp_t prep_in,
    output erlf_div_t      prep_out
);

    typedef struct packed {
        logic        valid;
        logic        bare;
        logic        degen;
        logic [32:0] den;
        logic [32:0] num1;
        logic [32:0] num2;
    } prep_t;

    prep_t            mid_reg;
    prep_t            mid_next;
    erlf_div_t        out_reg;
    erlf_div_t        out_next;
    logic [REM_W-1:0] dividend1;
    logic [REM_W-1:0] dividend2;
    logic [REM_W-1:0] limit;

    always_comb
    begin
        mid_next.valid = prep_in.valid;
        mid_next.bare  = prep_in.bare;
        mid_next.degen = !prep_in.bare && (prep_in.e_d == ONE_Q32);
        mid_next.den   = ONE_Q32 - prep_in.e_d;
        mid_next.num1  = ONE_Q32 - prep_in.e_1;
        // rounding can push the deeper exponential above the shallower one
        if (prep_in.e_12 > prep_in.e_1)
            mid_next.num2 = '0;
        else
            mid_next.num2 = prep_in.e_1 - prep_in.e_12;
    end

    always_comb
    begin
        dividend1 = (REM_W'(mid_reg.num1) << 16) + REM_W'(mid_reg.den >> 1);
        dividend2 = (REM_W'(mid_reg.num2) << 16) + REM_W'(mid_reg.den >> 1);
        // quotient exceeds 1.0 when dividend >= 65537 * den
        limit     = (REM_W'(mid_reg.den) << 16) + REM_W'(mid_reg.den);
        out_next.valid = mid_reg.valid;
        out_next.bare  = mid_reg.bare;
        out_next.degen = mid_reg.degen;
        out_next.sat1  = dividend1 >= limit;
        out_next.sat2  = dividend2 >= limit;
        out_next.den   = mid_reg.den;
        out_next.rem1  = dividend1;
        out_next.rem2  = dividend2;
        out_next.q1    = '0;
        out_next.q2    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
        end
        else if (advance)
        begin
            mid_reg <= mid_next;
            out_reg <= out_next;
        end
    end

    assign prep_out = out_reg;

endmodule

`default_nettype wire

@@ rtl/erlf_div_stage.sv @@
// ----------------------------------------------------------------------------
// erlf_div_stage
// One restoring division step for both fractions.
// ----------------------------------------------------------------------------
`default_nettype none

module erlf_div_stage
    import erlf_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire erlf_div_t stage_in,
    output erlf_div_t      stage_out
);

    erlf_div_t        stage_reg;
    erlf_div_t        stage_next;
    logic [REM_W-1:0] den_sh;

    always_comb
    begin
        den_sh     = REM_W'(stage_in.den) << BIT;
        stage_next = stage_in;
        if (stage_in.rem1 >= den_sh)
        begin
            stage_next.rem1    = stage_in.rem1 - den_sh;
            stage_next.q1[BIT] = 1'b1;
        end
        if (stage_in.rem2 >= den_sh)
        begin
            stage_next.rem2    = stage_in.rem2 - den_sh;
            stage_next.q2[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (advance)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

@@ rtl/exponential_root_layer_fractions.sv @@
// ----------------------------------------------------------------------------
// exponential_root_layer_fractions
// Root fractions of two soil layers under an exponential root profile.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low and returns results in
// order. The pipeline is one product stage, a 33-stage chain of rounding
// multiplies (one per exponent bit) for e^-x, two stages forming dividend
// and saturation, a 17-stage restoring divider and the output register.
// The whole pipeline holds while a result waits on out_stall.
`default_nettype none

module exponential_root_layer_fractions
    import erlf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  species_index,
    input  wire logic [15:0] root_decay,
    input  wire logic [15:0] soil_depth,
    input  wire logic [15:0] layer_one_depth,
    input  wire logic [15:0] layer_two_depth,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [16:0]      frac_layer_one,
    output logic [16:0]      frac_layer_two,
    output logic             degenerate_profile
);

    logic        advance;
    logic [4:0]  species_count_reg;
    erlf_exp_t   prod_next;
    erlf_exp_t   exp_chain [0:EXP_BITS];
    erlf_div_t   div_chain [0:FRAC_BITS];
    erlf_div_t   last;
    logic        out_valid_reg;
    logic [16:0] frac_one_reg;
    logic [16:0] frac_one_next;
    logic [16:0] frac_two_reg;
    logic [16:0] frac_two_next;
    logic        degen_reg;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            species_count_reg <= 5'd1;
        else if (cfg_valid)
            species_count_reg <= cfg_data;
    end

    always_comb
    begin
        prod_next.valid = in_valid;
        // a count of zero never matches since index + 1 is at least one
        prod_next.bare  = (5'(species_index) + 5'd1) == species_count_reg;
        prod_next.x_d   = 33'(root_decay) * 33'(soil_depth);
        prod_next.x_1   = 33'(root_decay) * 33'(layer_one_depth);
        prod_next.x_12  = 33'(root_decay)
                          * (33'(layer_one_depth) + 33'(layer_two_depth));
        prod_next.e_d   = ONE_Q32;
        prod_next.e_1   = ONE_Q32;
        prod_next.e_12  = ONE_Q32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_chain[0] <= '0;
        else if (advance)
            exp_chain[0] <= prod_next;
    end

    for (genvar g = 0; g < EXP_BITS; g++)
    begin : g_exp
        erlf_exp_stage #(.BIT(g)) u_exp (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .stage_in (exp_chain[g]),
            .stage_out(exp_chain[g+1])
        );
    end

    erlf_ratio_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .prep_in (exp_chain[EXP_BITS]),
        .prep_out(div_chain[0])
    );

    for (genvar g = 0; g < FRAC_BITS; g++)
    begin : g_div
        erlf_div_stage #(.BIT(FRAC_BITS - 1 - g)) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .stage_in (div_chain[g]),
            .stage_out(div_chain[g+1])
        );
    end

    assign last = div_chain[FRAC_BITS];

    always_comb
    begin
        if (last.bare || last.degen)
        begin
            frac_one_next = '0;
            frac_two_next = '0;
        end
        else
        begin
            frac_one_next = last.sat1 ? FRAC_ONE : last.q1;
            frac_two_next = last.sat2 ? FRAC_ONE : last.q2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            frac_one_reg  <= '0;
            frac_two_reg  <= '0;
            degen_reg     <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= last.valid;
            frac_one_reg  <= frac_one_next;
            frac_two_reg  <= frac_two_next;
            degen_reg     <= last.degen;
        end
    end

    assign out_valid          = out_valid_reg;
    assign frac_layer_one     = frac_one_reg;
    assign frac_layer_two     = frac_two_reg;
    assign degenerate_profile = degen_reg;

endmodule

`default_nettype wire

@@ rtl/erlf_checker.sv @@
// ----------------------------------------------------------------------------
// erlf_checker
// Port-level checks for the root fraction block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module erlf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [16:0] frac_layer_one,
    input wire logic [16:0] frac_layer_two,
    input wire logic        degenerate_profile
);

    `ERLF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
    `ERLF_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall)
    `ERLF_ASSERT(a_degen_zero, clk, rst_n, out_valid && degenerate_profile |-> frac_layer_one == 17'd0 && frac_layer_two == 17'd0)
    `ERLF_ASSERT(a_frac_range, clk, rst_n, out_valid |-> frac_layer_one <= 17'h1_0000 && frac_layer_two <= 17'h1_0000)
    `ERLF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid)

endmodule

bind exponential_root_layer_fractions erlf_checker u_erlf_checker (.*);

`default_nettype wire

@@ test/exponential_root_layer_fractions_test.sv @@
// ----------------------------------------------------------------------------
// exponential_root_layer_fractions_test
// Drives random and edge-case requests through the root fraction pipeline
// and checks every result against a fixed-point model of the same math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class root_fraction_board;
    logic [31:0]  exp_table [33];
    logic [4:0]   species_count;
    logic [34:0]  pending [$];   // {frac1, frac2, degen}
    int           mismatches;

    function new();
        longint unsigned term;
        longint unsigned sum;
        longint unsigned t;
        int              m;
        species_count = 5'd1;
        mismatches    = 0;
        t = 64'd0;
        for (int i = 0; i < 33; i++)
        begin
            if (i < 20)
            begin
                m    = 20 - i;
                term = 64'd1 << 60;
                sum  = 64'd1 << 60;
                for (int n = 1; n <= 40; n++)
                begin
                    term = (term >> m) / n;
                    if (n % 2 == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                t = (sum + (64'd1 << 27)) >> 28;
            end
            else
                t = (t * t + (64'd1 << 31)) >> 32;
            exp_table[i] = t[31:0];
        end
    endfunction

    function longint unsigned decay_exp(longint unsigned x);
        longint unsigned acc;
        acc = 64'd1 << 32;
        for (int i = 0; i < 33; i++)
            if (x[i])
                acc = (acc * exp_table[i] + (64'd1 << 31)) >> 32;
        return acc;
    endfunction

    function logic [16:0] layer_ratio(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = (num * 65536 + den / 2) / den;
        return (q > 65536) ? 17'h10000 : q[16:0];
    endfunction

    function void note_request(logic [3:0] sp, logic [15:0] k, logic [15:0] d,
                               logic [15:0] d1, logic [15:0] d2);
        longint unsigned e_d, e_1, e_12, den, num2;
        if (species_count != 0 && {1'b0, sp} == species_count - 5'd1)
        begin
            pending.push_back(35'd0);
            return;
        end
        e_d = decay_exp(longint'(k) * d);
        den = (64'd1 << 32) - e_d;
        if (den == 0)
        begin
            pending.push_back(35'd1);
            return;
        end
        e_1  = decay_exp(longint'(k) * d1);
        e_12 = decay_exp(longint'(k) * (longint'(d1) + d2));
        num2 = (e_12 > e_1) ? 0 : e_1 - e_12;
        pending.push_back({layer_ratio((64'd1 << 32) - e_1, den),
                           layer_ratio(num2, den), 1'b0});
    endfunction

    function void check_result(logic [16:0] f1, logic [16:0] f2, logic dg);
        logic [34:0] exp_val;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h %h %b", f1, f2, dg);
            return;
        end
        exp_val = pending.pop_front();
        if (exp_val !== {f1, f2, dg})
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h %h %b, got %h %h %b",
                         exp_val[34:18], exp_val[17:1], exp_val[0], f1, f2, dg);
        end
    endfunction
endclass

module exponential_root_layer_fractions_test;
    import erlf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  species_index = '0;
    logic [15:0] root_decay = '0;
    logic [15:0] soil_depth = '0;
    logic [15:0] layer_one_depth = '0;
    logic [15:0] layer_two_depth = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [16:0] frac_layer_one;
    logic [16:0] frac_layer_two;
    logic        degenerate_profile;

    root_fraction_board board = new();
    bit   stimulus_done = 1'b0;
    bit   hold_receiver = 1'b0;
    int   cycle_count = 0;

    localparam int PIPE_LATENCY = 54;
    localparam int CYCLE_LIMIT  = 400000;

    always #2 clk = ~clk;

    exponential_root_layer_fractions dut (.*);

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_species_count(logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.species_count = value;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        idle_cycles(PIPE_LATENCY + 4);
    endtask

    // Request is held until accepted; valid is left high on return, so requests without a gap go back to back.
    task automatic send_request(logic [3:0] sp, logic [15:0] k, logic [15:0] d,
                                logic [15:0] d1, logic [15:0] d2, bit keep_gap);
        int g;
        g = keep_gap ? gap_length() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            idle_cycles(g);
        end
        in_valid        <= 1'b1;
        species_index   <= sp;
        root_decay      <= k;
        soil_depth      <= d;
        layer_one_depth <= d1;
        layer_two_depth <= d2;
        do @(posedge clk); while (in_stall);
        board.note_request(sp, k, d, d1, d2);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 64));
            3: return 16'($urandom_range(256, 4096));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_phase(int count, logic [4:0] sc, bit gaps);
        logic [15:0] d, d1;
        for (int i = 0; i < count; i++)
        begin
            d  = pick_value();
            d1 = ($urandom_range(0, 3) == 0) ? pick_value() : 16'($urandom_range(0, d));
            send_request(($urandom_range(0, 3) == 0 && sc != 0) ? 4'(sc - 5'd1)
                                                               : 4'($urandom()),
                         pick_value(), d, d1, pick_value(), gaps);
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        idle_cycles(10);
        rst_n <= 1'b1;
        idle_cycles(2);

        // directed: bare ground, zero denominator, saturation, extremes
        send_request(4'd0, 16'd1024, 16'd2048, 16'd512, 16'd512, 1'b0);
        send_request(4'd1, 16'd1024, 16'd2048, 16'd512, 16'd512, 1'b0);
        send_request(4'd5, 16'd0, 16'd2048, 16'd512, 16'd512, 1'b0);
        send_request(4'd5, 16'd1024, 16'd0, 16'd512, 16'd512, 1'b0);
        send_request(4'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_request(4'hF, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
        send_request(4'd3, 16'd1024, 16'd512, 16'd4096, 16'd1024, 1'b0);
        send_request(4'd3, 16'd1, 16'd1, 16'd0, 16'd0, 1'b0);
        send_request(4'd2, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
        send_request(4'd2, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        send_request(4'd7, 16'd3000, 16'd1500, 16'd300, 16'd700, 1'b0);
        in_valid <= 1'b0;
        drain();

        write_species_count(5'd16);
        send_request(4'hF, 16'd1024, 16'd1024, 16'd100, 16'd100, 1'b0);
        send_request(4'hE, 16'd1024, 16'd1024, 16'd100, 16'd100, 1'b0);
        random_phase(150, 5'd16, 1'b1);
        drain();

        write_species_count(5'd0);
        random_phase(120, 5'd0, 1'b1);
        drain();

        write_species_count(5'd31);
        random_phase(80, 5'd31, 1'b1);
        drain();

        // long receiver hold while the sender keeps offering back to back
        write_species_count(5'd4);
        hold_receiver = 1'b1;
        random_phase(150, 5'd4, 1'b0);
        drain();

        write_species_count(5'd1);
        random_phase(100, 5'd1, 1'b1);
        drain();
        stimulus_done = 1'b1;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                hold_receiver = 1'b0;
                out_stall <= 1'b1;
                for (hold = 0; hold < 200; hold++)
                    @(posedge clk);
            end
            if ($urandom_range(0, 49) == 0)
            begin
                out_stall <= 1'b1;
                idle_cycles($urandom_range(10, 50));
                out_stall <= 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 99) < 20) ? 1'b1 : 1'b0;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(frac_layer_one, frac_layer_two, degenerate_profile);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (stimulus_done)
        begin
            if (board.mismatches == 0 && board.pending.size() == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
        else if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
